// ===== sv/sip_pkg.sv =====
// Shared types for the segment intersection point pipeline.
// No dependencies; imported by segment_intersection_point.
package sip_pkg;

    // Quotient digit of one radix-2 step of the scaled divider.
    typedef enum logic [1:0] {
        DIG_ZERO,
        DIG_ONE,
        DIG_TWO
    } sip_digit_t;

endpackage

// ===== sv/segment_intersection_point.sv =====
// Each divider pipeline stage takes one radix-2 step.
// Throughput: one word per cycle while out_stall is low; every stage holds its
// own valid bit and a stage that is empty or moving on takes the next word,
// so bubbles close up under stall.
// Reset: rst_n is asynchronous and active low; it clears all valid bits only.
// Depends on sip_pkg.
module segment_intersection_point #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] first_start_x,
    input  logic signed [COORD_WIDTH-1:0] first_start_y,
    input  logic signed [COORD_WIDTH-1:0] first_end_x,
    input  logic signed [COORD_WIDTH-1:0] first_end_y,
    input  logic signed [COORD_WIDTH-1:0] second_start_x,
    input  logic signed [COORD_WIDTH-1:0] second_start_y,
    input  logic signed [COORD_WIDTH-1:0] second_end_x,
    input  logic signed [COORD_WIDTH-1:0] second_end_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] cross_x,
    output logic signed [COORD_WIDTH-1:0] cross_y
);
    import sip_pkg::*;

    // Widths. Differences take one bit more than a coordinate; the
    // cross products take 2W+2 signed bits and their differences 2W+3.
    localparam int W   = COORD_WIDTH;
    localparam int AW  = W + 1;
    localparam int PW  = 2 * W + 2;
    localparam int DW  = 2 * W + 3;
    localparam int MW  = DW - 1;
    localparam int RW  = MW + 2;
    localparam int QW  = W + 2;
    localparam int DS  = AW;
    // Stage indexes: differences, products, cross terms, sign fix,
    // hit test, DS divider steps, quotient fix, output.
    localparam int ST_DIV0 = 4;
    localparam int ST_FIX  = ST_DIV0 + DS + 1;
    localparam int ST_OUT  = ST_FIX + 1;
    localparam int NST     = ST_OUT + 1;

    // The divider works on magnitudes. A stage advances when it is empty
    // or when the stage after it advances. The chain ends at the output.
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST:0]   en;

    always_comb
    begin
        en[NST] = ~out_stall;
        for (int i = NST - 1; i >= 0; i--)
        begin
            en[i] = ~vld_reg[i] | en[i+1];
        end
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int i = 1; i < NST; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = ~en[0];
    assign out_valid = vld_reg[ST_OUT];

    // Stage 0: edge vectors a = P1-P0, b = P3-P2 and c = P0-P2.
    logic signed [AW-1:0] s0_ax_reg, s0_ay_reg, s0_bx_reg, s0_by_reg, s0_cx_reg, s0_cy_reg;
    logic signed [W-1:0]  s0_px_reg, s0_py_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_ax_reg <= AW'(signed'({first_end_x[W-1], first_end_x}))
                         - AW'(signed'({first_start_x[W-1], first_start_x}));
            s0_ay_reg <= AW'(signed'({first_end_y[W-1], first_end_y}))
                         - AW'(signed'({first_start_y[W-1], first_start_y}));
            s0_bx_reg <= AW'(signed'({second_end_x[W-1], second_end_x}))
                         - AW'(signed'({second_start_x[W-1], second_start_x}));
            s0_by_reg <= AW'(signed'({second_end_y[W-1], second_end_y}))
                         - AW'(signed'({second_start_y[W-1], second_start_y}));
            s0_cx_reg <= AW'(signed'({first_start_x[W-1], first_start_x}))
                         - AW'(signed'({second_start_x[W-1], second_start_x}));
            s0_cy_reg <= AW'(signed'({first_start_y[W-1], first_start_y}))
                         - AW'(signed'({second_start_y[W-1], second_start_y}));
            s0_px_reg <= first_start_x;
            s0_py_reg <= first_start_y;
        end
    end

    // Stage 1: the six cross products, each one multiplier.
    logic signed [PW-1:0] s1_axby_reg, s1_bxay_reg, s1_axcy_reg;
    logic signed [PW-1:0] s1_aycx_reg, s1_bxcy_reg, s1_bycx_reg;
    logic signed [AW-1:0] s1_ax_reg, s1_ay_reg;
    logic signed [W-1:0]  s1_px_reg, s1_py_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_axby_reg <= PW'(s0_ax_reg) * PW'(s0_by_reg);
            s1_bxay_reg <= PW'(s0_bx_reg) * PW'(s0_ay_reg);
            s1_axcy_reg <= PW'(s0_ax_reg) * PW'(s0_cy_reg);
            s1_aycx_reg <= PW'(s0_ay_reg) * PW'(s0_cx_reg);
            s1_bxcy_reg <= PW'(s0_bx_reg) * PW'(s0_cy_reg);
            s1_bycx_reg <= PW'(s0_by_reg) * PW'(s0_cx_reg);
            s1_ax_reg   <= s0_ax_reg;
            s1_ay_reg   <= s0_ay_reg;
            s1_px_reg   <= s0_px_reg;
            s1_py_reg   <= s0_py_reg;
        end
    end

    // Stage 2: denominator and the two parameter numerators.
    logic signed [DW-1:0] s2_den_reg, s2_sn_reg, s2_tn_reg;
    logic signed [AW-1:0] s2_ax_reg, s2_ay_reg;
    logic signed [W-1:0]  s2_px_reg, s2_py_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_den_reg <= DW'(s1_axby_reg) - DW'(s1_bxay_reg);
            s2_sn_reg  <= DW'(s1_axcy_reg) - DW'(s1_aycx_reg);
            s2_tn_reg  <= DW'(s1_bxcy_reg) - DW'(s1_bycx_reg);
            s2_ax_reg  <= s1_ax_reg;
            s2_ay_reg  <= s1_ay_reg;
            s2_px_reg  <= s1_px_reg;
            s2_py_reg  <= s1_py_reg;
        end
    end

    // Stage 3: flip all three signs when the denominator is negative, so
    // the range tests below see a positive denominator.
    logic signed [DW-1:0] s3_den_reg, s3_sn_reg, s3_tn_reg;
    logic                 s3_nz_reg;
    logic signed [AW-1:0] s3_ax_reg, s3_ay_reg;
    logic signed [W-1:0]  s3_px_reg, s3_py_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_den_reg <= s2_den_reg[DW-1] ? -s2_den_reg : s2_den_reg;
            s3_sn_reg  <= s2_den_reg[DW-1] ? -s2_sn_reg : s2_sn_reg;
            s3_tn_reg  <= s2_den_reg[DW-1] ? -s2_tn_reg : s2_tn_reg;
            s3_nz_reg  <= (s2_den_reg != '0);
            s3_ax_reg  <= s2_ax_reg;
            s3_ay_reg  <= s2_ay_reg;
            s3_px_reg  <= s2_px_reg;
            s3_py_reg  <= s2_py_reg;
        end
    end

    // Stage 4 is divider entry: the hit test, and magnitudes for the
    // quotient floor(tn * |a| / den), which never exceeds |a| on a hit.
    logic signed [DW:0] s3_dms, s3_dmt;

    always_comb
    begin
        s3_dms = {s3_den_reg[DW-1], s3_den_reg} - {s3_sn_reg[DW-1], s3_sn_reg};
        s3_dmt = {s3_den_reg[DW-1], s3_den_reg} - {s3_tn_reg[DW-1], s3_tn_reg};
    end

    // Divider lanes: index 0 is filled from stage 3, index k holds the
    // state after k radix-2 steps.
    logic [MW-1:0] dv_den_reg [0:DS];
    logic [MW-1:0] dv_tn_reg  [0:DS];
    logic [AW-1:0] dv_mx_reg  [0:DS];
    logic [AW-1:0] dv_my_reg  [0:DS];
    logic [RW-1:0] dv_rx_reg  [0:DS];
    logic [RW-1:0] dv_ry_reg  [0:DS];
    logic [AW-1:0] dv_qx_reg  [0:DS];
    logic [AW-1:0] dv_qy_reg  [0:DS];
    logic          dv_nx_reg  [0:DS];
    logic          dv_ny_reg  [0:DS];
    logic          dv_hit_reg [0:DS];
    logic [W-1:0]  dv_px_reg  [0:DS];
    logic [W-1:0]  dv_py_reg  [0:DS];

    logic [RW-1:0] st_rx [1:DS];
    logic [RW-1:0] st_ry [1:DS];
    logic [AW-1:0] st_qx [1:DS];
    logic [AW-1:0] st_qy [1:DS];

    // One step: r = 2r + bit * tn, then take off 2*den or den if it fits. Since
    // r < den and tn <= den the sum stays below 3*den.
    always_comb
    begin
        logic [RW-1:0] r1, d1, d2;
        sip_digit_t    dig;
        for (int k = 1; k <= DS; k++)
        begin
            d1 = {2'b00, dv_den_reg[k-1]};
            d2 = {1'b0, dv_den_reg[k-1], 1'b0};

            r1 = {dv_rx_reg[k-1][RW-2:0], 1'b0}
                 + (dv_mx_reg[k-1][AW-1] ? {2'b00, dv_tn_reg[k-1]} : '0);
            if (r1 >= d2)
            begin
                dig = DIG_TWO;
            end
            else if (r1 >= d1)
            begin
                dig = DIG_ONE;
            end
            else
            begin
                dig = DIG_ZERO;
            end
            case (dig)
                DIG_TWO: st_rx[k] = r1 - d2;
                DIG_ONE: st_rx[k] = r1 - d1;
                default: st_rx[k] = r1;
            endcase
            st_qx[k] = {dv_qx_reg[k-1][AW-2:0], 1'b0} + AW'(dig);

            r1 = {dv_ry_reg[k-1][RW-2:0], 1'b0}
                 + (dv_my_reg[k-1][AW-1] ? {2'b00, dv_tn_reg[k-1]} : '0);
            if (r1 >= d2)
            begin
                dig = DIG_TWO;
            end
            else if (r1 >= d1)
            begin
                dig = DIG_ONE;
            end
            else
            begin
                dig = DIG_ZERO;
            end
            case (dig)
                DIG_TWO: st_ry[k] = r1 - d2;
                DIG_ONE: st_ry[k] = r1 - d1;
                default: st_ry[k] = r1;
            endcase
            st_qy[k] = {dv_qy_reg[k-1][AW-2:0], 1'b0} + AW'(dig);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_DIV0])
        begin
            dv_hit_reg[0] <= s3_nz_reg & ~s3_sn_reg[DW-1] & ~s3_tn_reg[DW-1]
                             & ~s3_dms[DW] & ~s3_dmt[DW];
            dv_den_reg[0] <= s3_den_reg[MW-1:0];
            dv_tn_reg[0]  <= s3_tn_reg[MW-1:0];
            dv_mx_reg[0]  <= s3_ax_reg[AW-1] ? (~s3_ax_reg + 1'b1) : s3_ax_reg;
            dv_my_reg[0]  <= s3_ay_reg[AW-1] ? (~s3_ay_reg + 1'b1) : s3_ay_reg;
            dv_nx_reg[0]  <= s3_ax_reg[AW-1];
            dv_ny_reg[0]  <= s3_ay_reg[AW-1];
            dv_rx_reg[0]  <= '0;
            dv_ry_reg[0]  <= '0;
            dv_qx_reg[0]  <= '0;
            dv_qy_reg[0]  <= '0;
            dv_px_reg[0]  <= s3_px_reg;
            dv_py_reg[0]  <= s3_py_reg;
        end
        for (int k = 1; k <= DS; k++)
        begin
            if (en[ST_DIV0+k])
            begin
                dv_hit_reg[k] <= dv_hit_reg[k-1];
                dv_den_reg[k] <= dv_den_reg[k-1];
                dv_tn_reg[k]  <= dv_tn_reg[k-1];
                dv_mx_reg[k]  <= {dv_mx_reg[k-1][AW-2:0], 1'b0};
                dv_my_reg[k]  <= {dv_my_reg[k-1][AW-2:0], 1'b0};
                dv_nx_reg[k]  <= dv_nx_reg[k-1];
                dv_ny_reg[k]  <= dv_ny_reg[k-1];
                dv_rx_reg[k]  <= st_rx[k];
                dv_ry_reg[k]  <= st_ry[k];
                dv_qx_reg[k]  <= st_qx[k];
                dv_qy_reg[k]  <= st_qy[k];
                dv_px_reg[k]  <= dv_px_reg[k-1];
                dv_py_reg[k]  <= dv_py_reg[k-1];
            end
        end
    end

    // Quotient fix: a negative numerator floors toward minus infinity, so
    // a nonzero remainder adds one to the magnitude before the negation.
    logic signed [QW-1:0] fx_qx_reg, fx_qy_reg;
    logic                 fx_hit_reg;
    logic signed [W-1:0]  fx_px_reg, fx_py_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_FIX])
        begin
            fx_qx_reg  <= dv_nx_reg[DS]
                          ? -(QW'(dv_qx_reg[DS]) + QW'(dv_rx_reg[DS] != '0))
                          : QW'(dv_qx_reg[DS]);
            fx_qy_reg  <= dv_ny_reg[DS]
                          ? -(QW'(dv_qy_reg[DS]) + QW'(dv_ry_reg[DS] != '0))
                          : QW'(dv_qy_reg[DS]);
            fx_hit_reg <= dv_hit_reg[DS];
            fx_px_reg  <= dv_px_reg[DS];
            fx_py_reg  <= dv_py_reg[DS];
        end
    end

    // Output: add the start point and clamp to the coordinate range; a miss gives zero.
    localparam logic signed [QW-1:0] CMAX = QW'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [QW-1:0] CMIN = -CMAX - QW'(1);

    logic signed [QW-1:0] sum_x, sum_y;
    logic                 hit_reg;
    logic signed [W-1:0]  cross_x_reg, cross_y_reg;

    assign sum_x = QW'(fx_px_reg) + fx_qx_reg;
    assign sum_y = QW'(fx_py_reg) + fx_qy_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            hit_reg <= fx_hit_reg;
            if (!fx_hit_reg)
            begin
                cross_x_reg <= '0;
                cross_y_reg <= '0;
            end
            else
            begin
                cross_x_reg <= (sum_x > CMAX) ? W'(CMAX) :
                               (sum_x < CMIN) ? W'(CMIN) : W'(sum_x);
                cross_y_reg <= (sum_y > CMAX) ? W'(CMAX) :
                               (sum_y < CMIN) ? W'(CMIN) : W'(sum_y);
            end
        end
    end

    assign hit     = hit_reg;
    assign cross_x = cross_x_reg;
    assign cross_y = cross_y_reg;

`ifndef SYNTHESIS
    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> cross_x == '0 && cross_y == '0)
        else $error("miss word carries a nonzero point");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> vld_reg[0])
        else $error("input stalled while first stage is empty");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_DIV0+DS] && dv_hit_reg[DS]
        |-> dv_rx_reg[DS] < {2'b00, dv_den_reg[DS]}
            && dv_ry_reg[DS] < {2'b00, dv_den_reg[DS]})
        else $error("divider remainder not below denominator");

    a_hit_needs_den: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_DIV0] && dv_hit_reg[0] |-> dv_den_reg[0] != '0)
        else $error("hit with zero denominator");
`endif

endmodule

// ===== tb/segment_intersection_point_tb.sv =====
// Self-checking testbench for segment_intersection_point: directed table then random pairs.
// Predicts results not typed in by exact wide arithmetic; depends only on the DUT and sip_pkg.
`timescale 1ns / 100ps

module segment_intersection_point_tb;

    localparam int CW = 32;
    localparam int N_RANDOM = 600;
    localparam int TAIL_CYCLES = 80;

    typedef logic signed [CW-1:0] coord_t;

    // One pair of segments, in port order.
    typedef struct packed {
        coord_t p0x;
        coord_t p0y;
        coord_t p1x;
        coord_t p1y;
        coord_t p2x;
        coord_t p2y;
        coord_t p3x;
        coord_t p3y;
    } seg_pair_t;

    // One intersection result word.
    typedef struct packed {
        logic   hit;
        coord_t x;
        coord_t y;
    } cross_word_t;

    // A directed row: when known is set, the typed-in result is compared instead of
    // the predicted one.
    typedef struct {
        seg_pair_t   pair;
        logic        known;
        cross_word_t want;
    } directed_row_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
    logic   out_valid;
    logic   out_stall;
    logic   hit;
    coord_t cross_x;
    coord_t cross_y;

    cross_word_t pending_crossings[$];
    int          mismatch_count;
    bit          quiet_phase;
    bit          long_hold;

    segment_intersection_point #(
        .COORD_WIDTH(CW)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_start_x  (first_start_x),
        .first_start_y  (first_start_y),
        .first_end_x    (first_end_x),
        .first_end_y    (first_end_y),
        .second_start_x (second_start_x),
        .second_start_y (second_start_y),
        .second_end_x   (second_end_x),
        .second_end_y   (second_end_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .cross_x        (cross_x),
        .cross_y        (cross_y)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Floor division toward minus infinity for a positive divisor.
    function automatic logic signed [191:0] floor_div(input logic signed [191:0] num,
                                                       input logic signed [191:0] den);
        logic signed [191:0] q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    // Clamp base plus offset to the signed coordinate range.
    function automatic coord_t clamp_coord(input logic signed [191:0] v);
        logic signed [191:0] hi;
        logic signed [191:0] lo;
        hi = (192'sd1 <<< (CW - 1)) - 1;
        lo = -(192'sd1 <<< (CW - 1));
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[CW-1:0];
    endfunction

    // Exact crossing point of two closed segments; a zero cross product means no hit.
    function automatic cross_word_t predict_crossing(input seg_pair_t s);
        logic signed [191:0] ax, ay, bx, by, cx, cy, den, sn, tn;
        cross_word_t r;
        ax = 192'(s.p1x) - 192'(s.p0x);
        ay = 192'(s.p1y) - 192'(s.p0y);
        bx = 192'(s.p3x) - 192'(s.p2x);
        by = 192'(s.p3y) - 192'(s.p2y);
        cx = 192'(s.p0x) - 192'(s.p2x);
        cy = 192'(s.p0y) - 192'(s.p2y);
        den = ax * by - bx * ay;
        sn = ax * cy - ay * cx;
        tn = bx * cy - by * cx;
        r = '0;
        if (den == 0)
            return r;
        if (den < 0)
        begin
            den = -den;
            sn = -sn;
            tn = -tn;
        end
        if (sn < 0 || tn < 0 || sn > den || tn > den)
            return r;
        r.hit = 1'b1;
        r.x = clamp_coord(192'(s.p0x) + floor_div(tn * ax, den));
        r.y = clamp_coord(192'(s.p0y) + floor_div(tn * ay, den));
        return r;
    endfunction

    function automatic coord_t q16(input int whole);
        return coord_t'(whole) <<< 16;
    endfunction

    // Mostly small segments around a shared area so many pairs cross, with
    // occasional full-range coordinates.
    function automatic coord_t random_coord(input int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 32'h0004_0000)) - coord_t'(32'h0002_0000);
            default: return q16($urandom_range(0, 20)) - q16(10);
        endcase
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t s;
        int mode;
        mode = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
        s.p0x = random_coord(mode);
        s.p0y = random_coord(mode);
        s.p1x = random_coord(mode);
        s.p1y = random_coord(mode);
        s.p2x = random_coord(mode);
        s.p2y = random_coord(mode);
        s.p3x = random_coord(mode);
        s.p3y = random_coord(mode);
        return s;
    endfunction

    function automatic seg_pair_t make_pair(input coord_t a, b, c, d, e, f, g, h);
        seg_pair_t s;
        s.p0x = a; s.p0y = b; s.p1x = c; s.p1y = d;
        s.p2x = e; s.p2y = f; s.p3x = g; s.p3y = h;
        return s;
    endfunction

    function automatic directed_row_t row(input seg_pair_t s, input logic known,
                                          input cross_word_t want);
        directed_row_t r;
        r.pair = s;
        r.known = known;
        r.want = want;
        return r;
    endfunction

    // Put one word on the input ports at the falling edge and hold it until taken.
    task automatic offer_pair(input seg_pair_t s, input cross_word_t expected);
        @(negedge clk);
        in_valid <= 1'b1;
        {first_start_x, first_start_y, first_end_x, first_end_y,
         second_start_x, second_start_y, second_end_x, second_end_y} <= s;
        do
            @(posedge clk);
        while (in_stall);
        pending_crossings.push_back(expected);
    endtask

    task automatic sender_gap();
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // Receiver side: random stall bursts, one long hold-off, none near the end.
    initial
    begin
        int burst;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (150)
                    @(negedge clk);
                out_stall <= 1'b0;
                long_hold = 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 11);
                out_stall <= 1'b1;
                repeat (burst)
                    @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Result checker: every accepted word is compared with the oldest expectation.
    always @(posedge clk)
    begin
        cross_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_crossings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected word hit=%0d x=%0h y=%0h", hit, cross_x, cross_y);
            end
            else
            begin
                want = pending_crossings.pop_front();
                if (hit !== want.hit || cross_x !== want.x || cross_y !== want.y)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: expected hit=%0d x=%0h y=%0h, got hit=%0d x=%0h y=%0h",
                                 want.hit, want.x, want.y, hit, cross_x, cross_y);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("segment_intersection_point test failed");
        $finish;
    end

    initial
    begin
        directed_row_t table_rows[$];
        cross_word_t none;
        cross_word_t mid;
        seg_pair_t s;
        coord_t mx;
        coord_t mn;
        int i;

        none = '0;
        mx = coord_t'(32'h7fff_ffff);
        mn = coord_t'(32'h8000_0000);
        mismatch_count = 0;
        quiet_phase = 0;
        long_hold = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        {first_start_x, first_start_y, first_end_x, first_end_y,
         second_start_x, second_start_y, second_end_x, second_end_y} = '0;

        // Crossing diagonals of a square meet at its centre.
        mid = '{1'b1, q16(1), q16(1)};
        table_rows.push_back(row(make_pair(0, 0, q16(2), q16(2), 0, q16(2), q16(2), 0), 1, mid));
        // Same pair with the second segment reversed: positive denominator.
        table_rows.push_back(row(make_pair(0, 0, q16(2), q16(2), q16(2), 0, 0, q16(2)), 1, mid));
        // Parallel segments.
        table_rows.push_back(row(make_pair(0, 0, q16(4), 0, 0, q16(1), q16(4), q16(1)),
                                 1, none));
        // Colinear overlapping segments.
        table_rows.push_back(row(make_pair(0, 0, q16(4), 0, q16(1), 0, q16(6), 0), 1, none));
        // All points equal, a degenerate pair.
        table_rows.push_back(row(make_pair(mx, mx, mx, mx, mx, mx, mx, mx), 1, none));
        table_rows.push_back(row(make_pair(mn, mn, mn, mn, mn, mn, mn, mn), 1, none));
        // Lines cross but outside the segments.
        table_rows.push_back(row(make_pair(0, 0, q16(1), 0, q16(5), q16(-1), q16(5), q16(1)),
                                 1, none));
        // Touch at an endpoint: both parameters at a bound.
        table_rows.push_back(row(make_pair(0, 0, q16(2), 0, q16(2), 0, q16(2), q16(3)),
                                 1, '{1'b1, q16(2), 0}));
        // T junction at the start of the first segment.
        table_rows.push_back(row(make_pair(0, 0, 0, q16(3), q16(-1), 0, q16(1), 0),
                                 1, '{1'b1, 0, 0}));
        // Full-range extremes, predicted.
        table_rows.push_back(row(make_pair(mn, mn, mx, mx, mn, mx, mx, mn), 0, none));
        table_rows.push_back(row(make_pair(mx, mn, mn, mx, mn, mn, mx, mx), 0, none));
        table_rows.push_back(row(make_pair(mn, 0, mx, 0, 0, mn, 0, mx), 0, none));
        table_rows.push_back(row(make_pair(-1, -1, 1, 1, -1, 1, 1, -1), 0, none));
        // Fractional result that needs floor rounding on a negative offset.
        table_rows.push_back(row(make_pair(0, 0, -3, -7, -5, 0, 0, -9), 0, none));
        table_rows.push_back(row(make_pair(q16(3), q16(3), q16(-3), q16(-3), q16(-3), q16(2),
                                           q16(3), q16(-1)), 0, none));
        table_rows.push_back(row(make_pair(mx, 0, mn, 0, 0, mx, 0, mn), 0, none));

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < table_rows.size(); i++)
        begin
            s = table_rows[i].pair;
            offer_pair(s, table_rows[i].known ? table_rows[i].want : predict_crossing(s));
        end

        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i == 100)
                long_hold = 1'b1;
            if (i == N_RANDOM - 80)
                quiet_phase = 1'b1;
            sender_gap();
            s = random_pair();
            offer_pair(s, predict_crossing(s));
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_crossings.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("segment_intersection_point test passed");
        else
            $display("segment_intersection_point test failed");
        $finish;
    end

endmodule
